// ----- rtl/core/cpe_pkg.sv -----
// Shared types and constants of the critical path engine.
package cpe_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int NODE_BITS  = 10;
   localparam int CNT_BITS   = 11;
   localparam int MAX_EDGES  = 4096;
   localparam int EDGE_BITS  = 12;
   localparam int EPTR_BITS  = 13;
   localparam int DEG_BITS   = 13;
   localparam int DUR_BITS   = 32;
   localparam int TIME_BITS  = 42;
   localparam int PROD_BITS  = 30;
   localparam int WIDE_BITS  = 60;
   localparam int RED_CNT_BITS = 6;

   localparam logic [PROD_BITS-1:0] MODULUS   = 30'd1000000007;
   localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
   localparam logic [EPTR_BITS-1:0] EDGE_NONE = 13'd4096;

   localparam int REQ_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 72;

   typedef enum logic [1:0] {
      CMD_SET_DURATION = 2'd0,
      CMD_ADD_EDGE     = 2'd1,
      CMD_COMPUTE      = 2'd2,
      CMD_CLEAR        = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CYCLE    = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_EDGE_WR, OP_CLR, OP_ZERO, OP_I_RESET, OP_CNT_RD_FIRST,
      OP_LOAD_E, OP_RD_EDGE, OP_I_INC, OP_TAKE_EDGE, OP_DEG_INC, OP_RD_DEG_I,
      OP_Q_PUSH, OP_POP, OP_SET_CYCLE, OP_B_START, OP_RD_NODE, OP_FWD_FIN,
      OP_FWD_RELAX, OP_B_POP, OP_BWD_INIT, OP_BWD_WRITE, OP_BWD_MIN, OP_RD_SLACK,
      OP_RED_TERM, OP_RED_STEP, OP_RED_PROD, OP_PROD_UPD, OP_RSP_LOAD
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_EDGE_WR, S_CLR, S_Z, S_CNT_I, S_CNT_F, S_CNT_E, S_CNT_T, S_CNT_W,
      S_Q_I, S_Q_C, S_P_H, S_P_U, S_P_F, S_P_E, S_P_T, S_P_W, S_B_I, S_B_U, S_B_F,
      S_B_E, S_B_T, S_B_C, S_M_I, S_M_T, S_M_R1, S_M_MUL, S_M_R2, S_M_UPD, S_FIN
   } state_type;

   typedef struct packed {
      logic i_lt_n;
      logic i_zero;
      logic clr_last;
      logic e_lt_ec;
      logic tgt_lt_n;
      logic head_lt_tail;
      logic tail_lt_n;
      logic ovf;
      logic red_done;
   } flags_type;

endpackage

// ----- rtl/core/critical_path_engine.sv -----
// Top level of the critical path engine.
//
// req channel carries one command per transfer: set a node duration, add an
// edge, compute, or clear. csr channel writes node_count (always ready).
// rsp channel returns one result per compute: project length, product of
// (slack+1) mod 1000000007, and a status (ok, cycle, edge table full).
// Clear writes one store entry per cycle after the transfer. In a
// compute the per-node modular product (two 60-step shift-subtract
// reductions) dominates; the rest is one store access per step of the
// topological and backward walks. After reset the block runs a clear
// before req_tready rises. A finished result sits in an output register;
// a new command is taken while it waits, and a following compute holds
// in its last step until the receiver takes the earlier result.
module critical_path_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // command
   input  logic [1:0]                           req_tuser,
   // node_index, duration, edge_source, edge_target, zero pad
   input  logic [cpe_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // status
   output logic [1:0]                           rsp_tuser,
   // total_time, slack_product
   output logic [cpe_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cpe_pkg::CNT_BITS-1:0]         csr_data
);
   import cpe_pkg::*;

   op_type    op;
   flags_type flags;

   assign csr_ready = 1'b1;

   cpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .op         (op)
   );

   cpe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .flags     (flags),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- rtl/core/cpe_ctrl.sv -----
// Sequencer of the critical path engine: command decode and compute phases.
module cpe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  cpe_pkg::flags_type   flags,
   output cpe_pkg::op_type      op
);
   import cpe_pkg::*;

   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   command_type cmd;

   assign cmd        = command_type'(req_tuser);
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op = OP_ACCEPT;
               case (cmd)
                  CMD_ADD_EDGE: state_in = S_EDGE_WR;
                  CMD_COMPUTE:  state_in = flags.ovf ? S_FIN : S_Z;
                  CMD_CLEAR:    state_in = S_CLR;
                  default:      state_in = S_IDLE;
               endcase
            end
         end
         S_EDGE_WR: begin
            op       = OP_EDGE_WR;
            state_in = S_IDLE;
         end
         S_CLR: begin
            op = OP_CLR;
            if (flags.clr_last) state_in = S_IDLE;
         end
         S_Z: begin
            if (flags.i_lt_n) op = OP_ZERO;
            else begin
               op       = OP_I_RESET;
               state_in = S_CNT_I;
            end
         end
         S_CNT_I: begin
            if (flags.i_lt_n) begin
               op       = OP_CNT_RD_FIRST;
               state_in = S_CNT_F;
            end else begin
               op       = OP_I_RESET;
               state_in = S_Q_I;
            end
         end
         S_CNT_F: begin
            op       = OP_LOAD_E;
            state_in = S_CNT_E;
         end
         S_CNT_E: begin
            if (flags.e_lt_ec) begin
               op       = OP_RD_EDGE;
               state_in = S_CNT_T;
            end else begin
               op       = OP_I_INC;
               state_in = S_CNT_I;
            end
         end
         S_CNT_T: begin
            op       = OP_TAKE_EDGE;
            state_in = flags.tgt_lt_n ? S_CNT_W : S_CNT_E;
         end
         S_CNT_W: begin
            op       = OP_DEG_INC;
            state_in = S_CNT_E;
         end
         S_Q_I: begin
            if (flags.i_lt_n) begin
               op       = OP_RD_DEG_I;
               state_in = S_Q_C;
            end else begin
               state_in = S_P_H;
            end
         end
         S_Q_C: begin
            op       = OP_Q_PUSH;
            state_in = S_Q_I;
         end
         S_P_H: begin
            if (flags.head_lt_tail) begin
               op       = OP_POP;
               state_in = S_P_U;
            end else if (flags.tail_lt_n) begin
               op       = OP_SET_CYCLE;
               state_in = S_FIN;
            end else begin
               op       = OP_B_START;
               state_in = S_B_I;
            end
         end
         S_P_U: begin
            op       = OP_RD_NODE;
            state_in = S_P_F;
         end
         S_P_F: begin
            op       = OP_FWD_FIN;
            state_in = S_P_E;
         end
         S_P_E: begin
            if (flags.e_lt_ec) begin
               op       = OP_RD_EDGE;
               state_in = S_P_T;
            end else begin
               state_in = S_P_H;
            end
         end
         S_P_T: begin
            op       = OP_TAKE_EDGE;
            state_in = flags.tgt_lt_n ? S_P_W : S_P_E;
         end
         S_P_W: begin
            op       = OP_FWD_RELAX;
            state_in = S_P_E;
         end
         S_B_I: begin
            if (!flags.i_zero) begin
               op       = OP_B_POP;
               state_in = S_B_U;
            end else begin
               op       = OP_I_RESET;
               state_in = S_M_I;
            end
         end
         S_B_U: begin
            op       = OP_RD_NODE;
            state_in = S_B_F;
         end
         S_B_F: begin
            op       = OP_BWD_INIT;
            state_in = S_B_E;
         end
         S_B_E: begin
            if (flags.e_lt_ec) begin
               op       = OP_RD_EDGE;
               state_in = S_B_T;
            end else begin
               op       = OP_BWD_WRITE;
               state_in = S_B_I;
            end
         end
         S_B_T: begin
            op       = OP_TAKE_EDGE;
            state_in = flags.tgt_lt_n ? S_B_C : S_B_E;
         end
         S_B_C: begin
            op       = OP_BWD_MIN;
            state_in = S_B_E;
         end
         S_M_I: begin
            if (flags.i_lt_n) begin
               op       = OP_RD_SLACK;
               state_in = S_M_T;
            end else begin
               state_in = S_FIN;
            end
         end
         S_M_T: begin
            op       = OP_RED_TERM;
            state_in = S_M_R1;
         end
         S_M_R1: begin
            op = OP_RED_STEP;
            if (flags.red_done) state_in = S_M_MUL;
         end
         S_M_MUL: begin
            op       = OP_RED_PROD;
            state_in = S_M_R2;
         end
         S_M_R2: begin
            op = OP_RED_STEP;
            if (flags.red_done) state_in = S_M_UPD;
         end
         S_M_UPD: begin
            op       = OP_PROD_UPD;
            state_in = S_M_I;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               op       = OP_RSP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (op == OP_RSP_LOAD) rsp_valid_in = 1'b1;
      else if (rsp_tready)   rsp_valid_in = 1'b0;
   end

endmodule

// ----- rtl/core/cpe_datapath.sv -----
// Graph stores, counters, path arithmetic and modular product of the engine.
module cpe_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cpe_pkg::op_type                      op,
   output cpe_pkg::flags_type                   flags,
   input  logic [1:0]                           req_tuser,
   input  logic [cpe_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                 csr_valid,
   input  logic [cpe_pkg::CNT_BITS-1:0]         csr_data,
   output logic [1:0]                           rsp_tuser,
   output logic [cpe_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);
   import cpe_pkg::*;

   // graph and schedule stores
   logic [DUR_BITS-1:0]  dur_mem   [MAX_NODES];
   logic [DEG_BITS-1:0]  deg_mem   [MAX_NODES];
   logic [EPTR_BITS-1:0] first_mem [MAX_NODES];
   logic [NODE_BITS-1:0] tgt_mem   [MAX_EDGES];
   logic [EPTR_BITS-1:0] nxt_mem   [MAX_EDGES];
   logic [TIME_BITS-1:0] earl_mem  [MAX_NODES];
   logic [TIME_BITS-1:0] late_mem  [MAX_NODES];
   logic [NODE_BITS-1:0] order_mem [MAX_NODES];

   logic [DUR_BITS-1:0]  dur_rd;
   logic [DEG_BITS-1:0]  deg_rd;
   logic [EPTR_BITS-1:0] first_rd;
   logic [NODE_BITS-1:0] tgt_rd;
   logic [EPTR_BITS-1:0] nxt_rd;
   logic [TIME_BITS-1:0] earl_rd;
   logic [TIME_BITS-1:0] late_rd;
   logic [NODE_BITS-1:0] order_rd;

   logic                 dur_we, deg_we, first_we, edge_we, earl_we, late_we, order_we;
   logic [NODE_BITS-1:0] dur_wa, deg_wa, first_wa, earl_wa, late_wa, order_wa;
   logic [EDGE_BITS-1:0] edge_wa;
   logic [DUR_BITS-1:0]  dur_wd;
   logic [DEG_BITS-1:0]  deg_wd;
   logic [EPTR_BITS-1:0] first_wd;
   logic [TIME_BITS-1:0] earl_wd, late_wd;
   logic [NODE_BITS-1:0] order_wd;

   logic [NODE_BITS-1:0] dur_ra, deg_ra, first_ra, earl_ra, late_ra, order_ra;
   logic [EDGE_BITS-1:0] edge_ra;

   // control counters
   logic [CNT_BITS-1:0]  i_ff, i_in, head_ff, head_in, tail_ff, tail_in;
   logic [CNT_BITS-1:0]  n_ff, n_in, node_count_ff, node_count_in;
   logic [EPTR_BITS-1:0] e_ff, e_in, ec_ff, ec_in;
   logic                 ovf_ff, ovf_in;

   // payload registers
   logic [NODE_BITS-1:0] u_ff, u_in, v_ff, v_in, src_ff, src_in, dst_ff, dst_in;
   logic [TIME_BITS-1:0] fin_ff, fin_in, total_ff, total_in, best_ff, best_in;
   logic                 any_ff, any_in;
   logic [DUR_BITS-1:0]  d_ff, d_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in, r_ff, r_in;
   logic [WIDE_BITS-1:0] val_ff, val_in;
   logic [RED_CNT_BITS-1:0] cnt_ff, cnt_in;
   status_type           status_ff, status_in, out_status_ff, out_status_in;
   logic [TIME_BITS-1:0] out_total_ff, out_total_in;
   logic [PROD_BITS-1:0] out_prod_ff, out_prod_in;

   // request fields
   logic [NODE_BITS-1:0] req_node, req_src, req_dst;
   logic [DUR_BITS-1:0]  req_dur;
   command_type          req_cmd;

   // arithmetic
   logic [CNT_BITS-1:0]  i_dec;
   logic [TIME_BITS:0]   fin_sum, term;
   logic [TIME_BITS-1:0] fin_val, cand;
   logic [PROD_BITS:0]   red_shift, red_sub;
   logic [WIDE_BITS-1:0] mul_w;
   logic                 edge_full;

   assign req_cmd  = command_type'(req_tuser);
   assign req_node = req_tdata[9:0];
   assign req_dur  = req_tdata[41:10];
   assign req_src  = req_tdata[51:42];
   assign req_dst  = req_tdata[61:52];

   assign i_dec     = i_ff - 11'd1;
   assign edge_full = (ec_ff == EPTR_BITS'(MAX_EDGES));
   assign fin_sum   = {1'b0, earl_rd} + {11'b0, dur_rd};
   assign fin_val   = (fin_sum > {1'b0, TIME_MAX}) ? TIME_MAX : fin_sum[TIME_BITS-1:0];
   assign cand      = late_rd - {10'b0, d_ff};
   assign term      = {1'b0, late_rd} - {1'b0, earl_rd} + 43'd1;
   assign red_shift = {r_ff, val_ff[WIDE_BITS-1]};
   assign red_sub   = red_shift - {1'b0, MODULUS};
   assign mul_w     = prod_ff * r_ff;

   assign flags.i_lt_n       = (i_ff < n_ff);
   assign flags.i_zero       = (i_ff == '0);
   assign flags.clr_last     = (i_ff[NODE_BITS-1:0] == {NODE_BITS{1'b1}});
   assign flags.e_lt_ec      = (e_ff < ec_ff);
   assign flags.tgt_lt_n     = ({1'b0, tgt_rd} < n_ff);
   assign flags.head_lt_tail = (head_ff < tail_ff);
   assign flags.tail_lt_n    = (tail_ff < n_ff);
   assign flags.ovf          = ovf_ff;
   assign flags.red_done     = (cnt_ff == '0);

   assign rsp_tdata = {out_prod_ff, out_total_ff};
   assign rsp_tuser = out_status_ff;

   always_comb begin
      i_in = i_ff;  head_in = head_ff;  tail_in = tail_ff;  n_in = n_ff;
      e_in = e_ff;  ec_in = ec_ff;  ovf_in = ovf_ff;
      node_count_in = csr_valid ? csr_data : node_count_ff;
      u_in = u_ff;  v_in = v_ff;  src_in = src_ff;  dst_in = dst_ff;
      fin_in = fin_ff;  total_in = total_ff;  best_in = best_ff;  any_in = any_ff;
      d_in = d_ff;  prod_in = prod_ff;  r_in = r_ff;  val_in = val_ff;  cnt_in = cnt_ff;
      status_in = status_ff;  out_status_in = out_status_ff;
      out_total_in = out_total_ff;  out_prod_in = out_prod_ff;

      dur_we = 1'b0;  dur_wa = i_ff[NODE_BITS-1:0];  dur_wd = '0;
      deg_we = 1'b0;  deg_wa = i_ff[NODE_BITS-1:0];  deg_wd = '0;
      first_we = 1'b0;  first_wa = i_ff[NODE_BITS-1:0];  first_wd = EDGE_NONE;
      edge_we = 1'b0;  edge_wa = ec_ff[EDGE_BITS-1:0];
      earl_we = 1'b0;  earl_wa = i_ff[NODE_BITS-1:0];  earl_wd = '0;
      late_we = 1'b0;  late_wa = u_ff;  late_wd = best_ff;
      order_we = 1'b0;  order_wa = tail_ff[NODE_BITS-1:0];  order_wd = i_ff[NODE_BITS-1:0];

      dur_ra   = order_rd;
      deg_ra   = tgt_rd;
      first_ra = order_rd;
      edge_ra  = e_ff[EDGE_BITS-1:0];
      earl_ra  = tgt_rd;
      late_ra  = tgt_rd;
      order_ra = head_ff[NODE_BITS-1:0];

      unique case (op)
         OP_NONE: ;
         OP_ACCEPT: begin
            src_in    = req_src;
            dst_in    = req_dst;
            first_ra  = req_src;
            i_in      = '0;
            n_in      = (node_count_ff > CNT_BITS'(MAX_NODES)) ? CNT_BITS'(MAX_NODES)
                                                               : node_count_ff;
            total_in  = '0;
            prod_in   = 30'd1;
            status_in = ovf_ff ? ST_OVERFLOW : ST_OK;
            if (req_cmd == CMD_SET_DURATION) begin
               dur_we = 1'b1;
               dur_wa = req_node;
               dur_wd = req_dur;
            end
         end
         OP_EDGE_WR: begin
            if (edge_full) ovf_in = 1'b1;
            else begin
               edge_we  = 1'b1;
               first_we = 1'b1;
               first_wa = src_ff;
               first_wd = ec_ff;
               ec_in    = ec_ff + 13'd1;
            end
         end
         OP_CLR: begin
            dur_we   = 1'b1;
            first_we = 1'b1;
            i_in     = i_ff + 11'd1;
            ec_in    = '0;
            ovf_in   = 1'b0;
         end
         OP_ZERO: begin
            deg_we  = 1'b1;
            earl_we = 1'b1;
            i_in    = i_ff + 11'd1;
         end
         OP_I_RESET: begin
            i_in    = '0;
            head_in = '0;
            tail_in = '0;
         end
         OP_CNT_RD_FIRST: first_ra = i_ff[NODE_BITS-1:0];
         OP_LOAD_E:       e_in = first_rd;
         OP_RD_EDGE:      edge_ra = e_ff[EDGE_BITS-1:0];
         OP_I_INC:        i_in = i_ff + 11'd1;
         OP_TAKE_EDGE: begin
            v_in = tgt_rd;
            e_in = nxt_rd;
         end
         OP_DEG_INC: begin
            deg_we = 1'b1;
            deg_wa = v_ff;
            deg_wd = deg_rd + 13'd1;
         end
         OP_RD_DEG_I: deg_ra = i_ff[NODE_BITS-1:0];
         OP_Q_PUSH: begin
            if (deg_rd == '0) begin
               order_we = 1'b1;
               tail_in  = tail_ff + 11'd1;
            end
            i_in = i_ff + 11'd1;
         end
         OP_POP:       head_in = head_ff + 11'd1;
         OP_SET_CYCLE: status_in = ST_CYCLE;
         OP_B_START:   i_in = tail_ff;
         OP_RD_NODE: begin
            u_in    = order_rd;
            earl_ra = order_rd;
         end
         OP_FWD_FIN: begin
            fin_in   = fin_val;
            total_in = (fin_val > total_ff) ? fin_val : total_ff;
            e_in     = first_rd;
         end
         OP_FWD_RELAX: begin
            earl_we = 1'b1;
            earl_wa = v_ff;
            earl_wd = (fin_ff > earl_rd) ? fin_ff : earl_rd;
            deg_we  = 1'b1;
            deg_wa  = v_ff;
            deg_wd  = deg_rd - 13'd1;
            if (deg_rd == 13'd1) begin
               order_we = 1'b1;
               order_wd = v_ff;
               tail_in  = tail_ff + 11'd1;
            end
         end
         OP_B_POP: begin
            order_ra = i_dec[NODE_BITS-1:0];
            i_in     = i_dec;
         end
         OP_BWD_INIT: begin
            d_in   = dur_rd;
            e_in   = first_rd;
            any_in = 1'b0;
         end
         OP_BWD_WRITE: begin
            late_we = 1'b1;
            late_wd = any_ff ? best_ff : (total_ff - {10'b0, d_ff});
         end
         OP_BWD_MIN: begin
            if (!any_ff || (cand < best_ff)) best_in = cand;
            any_in = 1'b1;
         end
         OP_RD_SLACK: begin
            earl_ra = i_ff[NODE_BITS-1:0];
            late_ra = i_ff[NODE_BITS-1:0];
         end
         OP_RED_TERM: begin
            val_in = {17'b0, term};
            r_in   = '0;
            cnt_in = RED_CNT_BITS'(WIDE_BITS - 1);
         end
         OP_RED_STEP: begin
            r_in   = red_sub[PROD_BITS] ? red_shift[PROD_BITS-1:0] : red_sub[PROD_BITS-1:0];
            val_in = {val_ff[WIDE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
         end
         OP_RED_PROD: begin
            val_in = mul_w;
            r_in   = '0;
            cnt_in = RED_CNT_BITS'(WIDE_BITS - 1);
         end
         OP_PROD_UPD: begin
            prod_in = r_ff;
            i_in    = i_ff + 11'd1;
         end
         OP_RSP_LOAD: begin
            out_status_in = status_ff;
            out_total_in  = (status_ff == ST_OK) ? total_ff : '0;
            out_prod_in   = (status_ff == ST_OK) ? prod_ff : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff          <= '0;
         ec_ff         <= '0;
         ovf_ff        <= 1'b0;
         node_count_ff <= 11'd1;
      end else begin
         i_ff          <= i_in;
         ec_ff         <= ec_in;
         ovf_ff        <= ovf_in;
         node_count_ff <= node_count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;  tail_ff <= tail_in;  n_ff <= n_in;  e_ff <= e_in;
      u_ff <= u_in;  v_ff <= v_in;  src_ff <= src_in;  dst_ff <= dst_in;
      fin_ff <= fin_in;  total_ff <= total_in;  best_ff <= best_in;  any_ff <= any_in;
      d_ff <= d_in;  prod_ff <= prod_in;  r_ff <= r_in;  val_ff <= val_in;
      cnt_ff <= cnt_in;  status_ff <= status_in;  out_status_ff <= out_status_in;
      out_total_ff <= out_total_in;  out_prod_ff <= out_prod_in;
   end

   always_ff @(posedge clock) begin
      if (dur_we) dur_mem[dur_wa] <= dur_wd;
      dur_rd <= dur_mem[dur_ra];
   end

   always_ff @(posedge clock) begin
      if (deg_we) deg_mem[deg_wa] <= deg_wd;
      deg_rd <= deg_mem[deg_ra];
   end

   always_ff @(posedge clock) begin
      if (first_we) first_mem[first_wa] <= first_wd;
      first_rd <= first_mem[first_ra];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         tgt_mem[edge_wa] <= dst_ff;
         nxt_mem[edge_wa] <= first_rd;
      end
      tgt_rd <= tgt_mem[edge_ra];
      nxt_rd <= nxt_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (earl_we) earl_mem[earl_wa] <= earl_wd;
      earl_rd <= earl_mem[earl_ra];
   end

   always_ff @(posedge clock) begin
      if (late_we) late_mem[late_wa] <= late_wd;
      late_rd <= late_mem[late_ra];
   end

   always_ff @(posedge clock) begin
      if (order_we) order_mem[order_wa] <= order_wd;
      order_rd <= order_mem[order_ra];
   end

endmodule

// ----- tb/tb_critical_path_engine.sv -----
// Testbench for critical_path_engine: random and directed task graphs checked against a predictor.
module tb_critical_path_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import cpe_pkg::*;

   typedef struct {
      logic [TIME_BITS-1:0] total;
      logic [PROD_BITS-1:0] product;
      status_type           status;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = CMD_SET_DURATION;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [1:0] rsp_tuser;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CNT_BITS-1:0] csr_data = '0;

   outcome_type pending_outcomes[$];
   int error_count = 0;
   int item_count = 0;
   bit idling = 1'b1;
   int rsp_hold = 0;

   // graph mirror
   int node_total = 1;
   logic [DUR_BITS-1:0] task_length[MAX_NODES];
   int first_arc[MAX_NODES];
   int arc_target[MAX_EDGES];
   int arc_next[MAX_EDGES];
   int arc_count = 0;
   bit arc_overflow = 1'b0;
   int pred_left[MAX_NODES];
   longint unsigned early_start[MAX_NODES];
   longint late_start[MAX_NODES];
   int topo_order[MAX_NODES];

   critical_path_engine u_top (.*);

   always #1 clock = ~clock;

   initial begin
      #6000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void wipe_graph();
      for (int i = 0; i < MAX_NODES; i++) begin
         task_length[i] = '0;
         first_arc[i] = MAX_EDGES;
         early_start[i] = 0;
      end
      arc_count = 0;
      arc_overflow = 1'b0;
   endfunction

   function automatic outcome_type schedule_graph();
      outcome_type res;
      int n, head, tail, u, v;
      longint unsigned fin, total, prod;
      longint d, best, cand, term;
      bit any;
      n = (node_total > MAX_NODES) ? MAX_NODES : node_total;
      head = 0;
      tail = 0;
      total = 0;
      prod = 1;
      res.total = '0;
      res.product = '0;
      if (arc_overflow) begin
         res.status = ST_OVERFLOW;
         return res;
      end
      for (int i = 0; i < n; i++) begin
         pred_left[i] = 0;
         early_start[i] = 0;
      end
      for (int i = 0; i < n; i++)
         for (int e = first_arc[i]; e < arc_count; e = arc_next[e])
            if (arc_target[e] < n) pred_left[arc_target[e]]++;
      for (int i = 0; i < n; i++)
         if (pred_left[i] == 0) topo_order[tail++] = i;
      while (head < tail) begin
         u = topo_order[head++];
         fin = early_start[u] + task_length[u];
         if (fin > TIME_MAX) fin = TIME_MAX;
         if (fin > total) total = fin;
         for (int e = first_arc[u]; e < arc_count; e = arc_next[e]) begin
            v = arc_target[e];
            if (v < n) begin
               if (fin > early_start[v]) early_start[v] = fin;
               if (--pred_left[v] == 0) topo_order[tail++] = v;
            end
         end
      end
      if (tail < n) begin
         res.status = ST_CYCLE;
         return res;
      end
      for (int i = n; i > 0; i--) begin
         u = topo_order[i-1];
         d = longint'(task_length[u]);
         best = 0;
         any = 1'b0;
         for (int e = first_arc[u]; e < arc_count; e = arc_next[e]) begin
            v = arc_target[e];
            if (v < n) begin
               cand = late_start[v] - d;
               if (!any || cand < best) best = cand;
               any = 1'b1;
            end
         end
         late_start[u] = any ? best : longint'(total) - d;
      end
      for (int i = 0; i < n; i++) begin
         term = (late_start[i] - longint'(early_start[i]) + 1) % longint'(MODULUS);
         if (term < 0) term += longint'(MODULUS);
         prod = (prod * longint'(term)) % longint'(MODULUS);
      end
      res.total = total[TIME_BITS-1:0];
      res.product = prod[PROD_BITS-1:0];
      res.status = ST_OK;
      return res;
   endfunction

   function automatic void apply_command(command_type cmd, int node, logic [31:0] dur,
                                         int src, int dst);
      case (cmd)
         CMD_SET_DURATION: task_length[node] = dur;
         CMD_ADD_EDGE: begin
            if (arc_count >= MAX_EDGES) arc_overflow = 1'b1;
            else begin
               arc_target[arc_count] = dst;
               arc_next[arc_count] = first_arc[src];
               first_arc[src] = arc_count;
               arc_count++;
            end
         end
         CMD_COMPUTE: pending_outcomes.insert(pending_outcomes.size(), schedule_graph());
         default: wipe_graph();
      endcase
   endfunction

   task automatic send_command(command_type cmd, int node = 0, logic [31:0] dur = 0,
                               int src = 0, int dst = 0);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {2'b00, dst[9:0], src[9:0], dur, node[9:0]};
      do @(posedge clock); while (!req_tready);
      apply_command(cmd, node, dur, src, dst);
      item_count++;
   endtask

   task automatic load_node_count(int count);
      req_tvalid <= 1'b0;
      wait (pending_outcomes.size() == 0);
      repeat (1100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= count[CNT_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      node_total = count;
   endtask

   // result channel stall
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_hold <= $urandom_range(1, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result transfer");
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[TIME_BITS-1:0] !== want.total) begin
               $error("total_time expected %0d actual %0d", want.total,
                      rsp_tdata[TIME_BITS-1:0]);
               error_count++;
            end
            if (rsp_tdata[TIME_BITS +: PROD_BITS] !== want.product) begin
               $error("slack_product expected %0d actual %0d", want.product,
                      rsp_tdata[TIME_BITS +: PROD_BITS]);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   task automatic test_basic_graphs();
      send_command(CMD_COMPUTE);
      load_node_count(4);
      send_command(CMD_SET_DURATION, 0, 32'hFFFF_FFFF);
      send_command(CMD_SET_DURATION, 1, 5);
      send_command(CMD_SET_DURATION, 2, 32'h8000_0001);
      send_command(CMD_SET_DURATION, 1023, 7);
      send_command(CMD_ADD_EDGE, 0, 0, 0, 1);
      send_command(CMD_ADD_EDGE, 0, 0, 1, 3);
      send_command(CMD_ADD_EDGE, 0, 0, 2, 1023);
      send_command(CMD_ADD_EDGE, 0, 0, 1023, 0);
      send_command(CMD_COMPUTE);
      send_command(CMD_COMPUTE);
      send_command(CMD_ADD_EDGE, 0, 0, 3, 0);
      send_command(CMD_COMPUTE);
      send_command(CMD_CLEAR);
      send_command(CMD_ADD_EDGE, 0, 0, 2, 2);
      send_command(CMD_COMPUTE);
      send_command(CMD_CLEAR);
      send_command(CMD_COMPUTE);
      load_node_count(0);
      send_command(CMD_COMPUTE);
   endtask

   task automatic test_count_extremes();
      load_node_count(2047);
      for (int i = 0; i < 60; i++) begin
         send_command(CMD_SET_DURATION, $urandom_range(0, 1023), $urandom());
         send_command(CMD_ADD_EDGE, 0, 0, $urandom_range(0, 511), $urandom_range(512, 1023));
      end
      send_command(CMD_COMPUTE);
      load_node_count(MAX_NODES);
      send_command(CMD_COMPUTE);
   endtask

   task automatic test_edge_overflow();
      load_node_count(8);
      send_command(CMD_CLEAR);
      for (int i = 0; i <= MAX_EDGES; i++)
         send_command(CMD_ADD_EDGE, 0, 0, $urandom_range(0, 7), $urandom_range(0, 7));
      send_command(CMD_COMPUTE);
      send_command(CMD_CLEAR);
      send_command(CMD_COMPUTE);
   endtask

   task automatic test_random_graphs();
      int n, steps, pick, a, b, start;
      start = item_count;
      while (item_count - start < 650) begin
         if (item_count - start > 520) idling = 1'b0;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         if ($urandom_range(0, 2) != 0) load_node_count(n);
         else n = node_total;
         if ($urandom_range(0, 1) == 0) send_command(CMD_CLEAR);
         steps = $urandom_range(5, 20);
         repeat (steps) begin
            pick = $urandom_range(0, 9);
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            if (pick < 4)
               send_command(CMD_SET_DURATION, (pick == 0) ? $urandom_range(0, 1023) : a,
                            $urandom());
            else if (pick < 9) begin
               if (a != b)
                  send_command(CMD_ADD_EDGE, 0, 0, (a < b) ? a : b, (a < b) ? b : a);
            end else
               send_command(CMD_ADD_EDGE, 0, 0, $urandom_range(0, 1023),
                            $urandom_range(0, 1023));
         end
         send_command(CMD_COMPUTE);
         if ($urandom_range(0, 4) == 0) send_command(CMD_COMPUTE);
      end
   endtask

   initial begin
      wipe_graph();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_basic_graphs();
      test_count_extremes();
      test_edge_overflow();
      test_random_graphs();
      req_tvalid <= 1'b0;
      wait (pending_outcomes.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
